/* hdl/humidity_sensor_measure_sequencer_top_defines.svh */
// Assertion macros shared by the sequencer RTL.
`ifndef HUMIDITY_SENSOR_MEASURE_SEQUENCER_TOP_DEFINES_SVH
`define HUMIDITY_SENSOR_MEASURE_SEQUENCER_TOP_DEFINES_SVH

// The condition must hold at every clock edge out of reset.
`define HSMS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define HSMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/hsms_pkg.sv */
`default_nettype none

package hsms_pkg;

    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_HEATER = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVALID     = 3'd1;
    localparam logic [2:0] ST_NOT_STARTED = 3'd2;
    localparam logic [2:0] ST_MEASURING   = 3'd3;
    localparam logic [2:0] ST_CRC_TEMP    = 3'd4;
    localparam logic [2:0] ST_CRC_HUM     = 3'd5;

    localparam logic [2:0] MODE_SINGLE = 3'd0;
    localparam logic [2:0] MODE_MAX    = 3'd5;
    localparam logic [1:0] REP_MAX     = 2'd2;

    localparam logic [15:0] CMD_CLEAR_STATUS = 16'h3041;
    localparam logic [15:0] CMD_STOP         = 16'h3093;
    localparam logic [15:0] CMD_HEATER_ON    = 16'h306D;
    localparam logic [15:0] CMD_HEATER_OFF   = 16'h3066;
    localparam logic [15:0] CMD_FETCH        = 16'hE000;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    localparam logic [30:0] TEMP_SPAN   = 31'd17500;
    localparam logic [29:0] HUM_SPAN    = 30'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;

    localparam logic [15:0] MEAS_CMD [0:5][0:2] = '{
        '{16'h2400, 16'h240B, 16'h2416},
        '{16'h2032, 16'h2024, 16'h202F},
        '{16'h2130, 16'h2126, 16'h212D},
        '{16'h2236, 16'h2220, 16'h222B},
        '{16'h2334, 16'h2322, 16'h2329},
        '{16'h2737, 16'h2721, 16'h272A}
    };

    localparam logic [15:0] WINDOW_US [0:3] = '{16'd15000, 16'd6000, 16'd4000, 16'd0};

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            if (crc[7]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

    function automatic logic [7:0] crc8_pair(input logic [7:0] b0, input logic [7:0] b1);
        return crc8_byte(crc8_byte(CRC_INIT, b0), b1);
    endfunction

endpackage

`default_nettype wire

/* hdl/hsms_in_if.sv */
`default_nettype none

interface hsms_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [2:0]  mode;
    logic [1:0]  repeatability;
    logic        heater_on;
    logic [47:0] frame_bytes;

    modport source (
        output valid, op, mode, repeatability, heater_on, frame_bytes,
        input  ready
    );
    modport sink (
        input  valid, op, mode, repeatability, heater_on, frame_bytes,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/hsms_out_if.sv */
`default_nettype none

interface hsms_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic               cmd_valid;
    logic [15:0]        cmd_word;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;

    modport source (
        output valid, status, cmd_valid, cmd_word, temperature_centi, humidity_centi,
        input  ready
    );
    modport sink (
        input  valid, status, cmd_valid, cmd_word, temperature_centi, humidity_centi,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/humidity_sensor_measure_sequencer_top.sv */
// Measurement sequencer for a temperature and humidity sensor. Each input word is one
// operation (init, start, stop, heater, tick or read) and yields exactly one result word
// with a status, an optional 16-bit sensor command and, on a good read, the converted
// temperature and humidity. The block takes one word per clock cycle while the output is
// not stalled. The result is offered once the input register and then the result register
// are loaded. The input register also holds both CRC checks and the scaling products. One
// pass of logic then updates the sequencer state, decides status and command, and finishes
// the scaling into the result register. A stalled output holds the input register and the
// input. Write us_per_tick only while no word is in flight.
`default_nettype none
`include "humidity_sensor_measure_sequencer_top_defines.svh"

module humidity_sensor_measure_sequencer_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [9:0] i_cfg_wdata,
    hsms_in_if.sink         i_in,
    hsms_out_if.source      o_out
);

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  mode;
        logic [1:0]  repeatability;
        logic        heater_on;
        logic        crc_temp_ok;
        logic        crc_hum_ok;
        logic [30:0] prod_temp;
        logic [29:0] prod_hum;
    } t_in_stage;

    typedef struct packed {
        logic [2:0]  status;
        logic        cmd_valid;
        logic [15:0] cmd_word;
        logic        ok;
    } t_result;

    logic               w_advance;
    t_in_stage          w_in;
    logic [15:0]        w_raw_temp;
    logic [15:0]        w_raw_hum;

    logic               r_in_valid;
    t_in_stage          r_in;
    logic               r_out_valid;
    logic [2:0]         r_out_status;
    logic               r_out_cmd_valid;
    logic [15:0]        r_out_cmd_word;
    logic signed [14:0] r_out_temp;
    logic [13:0]        r_out_hum;

    logic [9:0]         r_us_per_tick;
    logic [2:0]         r_active_mode;
    logic [1:0]         r_active_repeat;
    logic               r_started;
    logic               r_first;
    logic [15:0]        r_elapsed;

    logic [2:0]         n_active_mode;
    logic [1:0]         n_active_repeat;
    logic               n_started;
    logic               n_first;
    logic [15:0]        n_elapsed;
    t_result            n_result;
    logic [16:0]        w_tick_sum;

    logic signed [14:0] w_temp;
    logic [13:0]        w_hum;

    assign w_advance = !r_out_valid || o_out.ready;
    assign i_in.ready = w_advance;

    assign w_raw_temp = i_in.frame_bytes[47:32];
    assign w_raw_hum  = i_in.frame_bytes[23:8];

    always_comb begin
        w_in.op            = i_in.op;
        w_in.mode          = i_in.mode;
        w_in.repeatability = i_in.repeatability;
        w_in.heater_on     = i_in.heater_on;
        w_in.crc_temp_ok   = hsms_pkg::crc8_pair(i_in.frame_bytes[47:40],
                             i_in.frame_bytes[39:32]) == i_in.frame_bytes[31:24];
        w_in.crc_hum_ok    = hsms_pkg::crc8_pair(i_in.frame_bytes[23:16],
                             i_in.frame_bytes[15:8]) == i_in.frame_bytes[7:0];
        w_in.prod_temp     = {15'd0, w_raw_temp} * hsms_pkg::TEMP_SPAN;
        w_in.prod_hum      = {14'd0, w_raw_hum} * hsms_pkg::HUM_SPAN;
    end

    assign w_tick_sum = {1'b0, r_elapsed} + {7'd0, r_us_per_tick};

    always_comb begin
        n_active_mode      = r_active_mode;
        n_active_repeat    = r_active_repeat;
        n_started          = r_started;
        n_first            = r_first;
        n_elapsed          = r_elapsed;
        n_result.status    = hsms_pkg::ST_OK;
        n_result.cmd_valid = 1'b0;
        n_result.cmd_word  = 16'd0;
        n_result.ok        = 1'b0;
        case (r_in.op)
            hsms_pkg::OP_INIT, hsms_pkg::OP_STOP: begin
                n_active_mode      = hsms_pkg::MODE_SINGLE;
                n_started          = 1'b0;
                n_first            = 1'b0;
                n_elapsed          = 16'd0;
                n_result.cmd_valid = 1'b1;
                n_result.cmd_word  = (r_in.op == hsms_pkg::OP_INIT) ?
                                     hsms_pkg::CMD_CLEAR_STATUS : hsms_pkg::CMD_STOP;
            end
            hsms_pkg::OP_START: begin
                if (r_in.mode > hsms_pkg::MODE_MAX || r_in.repeatability > hsms_pkg::REP_MAX) begin
                    n_result.status = hsms_pkg::ST_INVALID;
                end else begin
                    n_active_mode      = r_in.mode;
                    n_active_repeat    = r_in.repeatability;
                    n_started          = 1'b1;
                    n_first            = 1'b1;
                    n_elapsed          = 16'd0;
                    n_result.cmd_valid = 1'b1;
                    n_result.cmd_word  = hsms_pkg::MEAS_CMD[r_in.mode][r_in.repeatability];
                end
            end
            hsms_pkg::OP_HEATER: begin
                n_result.cmd_valid = 1'b1;
                n_result.cmd_word  = r_in.heater_on ? hsms_pkg::CMD_HEATER_ON :
                                     hsms_pkg::CMD_HEATER_OFF;
            end
            hsms_pkg::OP_TICK: begin
                n_elapsed = w_tick_sum[16] ? hsms_pkg::ELAPSED_MAX : w_tick_sum[15:0];
            end
            hsms_pkg::OP_READ: begin
                if (!r_started) begin
                    n_result.status = hsms_pkg::ST_NOT_STARTED;
                end else if (r_first && r_elapsed < hsms_pkg::WINDOW_US[r_active_repeat]) begin
                    n_result.status = hsms_pkg::ST_MEASURING;
                end else begin
                    if (r_active_mode != hsms_pkg::MODE_SINGLE) begin
                        n_result.cmd_valid = 1'b1;
                        n_result.cmd_word  = hsms_pkg::CMD_FETCH;
                    end else begin
                        n_started = 1'b0;
                    end
                    n_first = 1'b0;
                    if (!r_in.crc_temp_ok) begin
                        n_result.status = hsms_pkg::ST_CRC_TEMP;
                    end else if (!r_in.crc_hum_ok) begin
                        n_result.status = hsms_pkg::ST_CRC_HUM;
                    end else begin
                        n_result.ok = 1'b1;
                    end
                end
            end
            default: begin
                n_result.status = hsms_pkg::ST_INVALID;
            end
        endcase
    end

    hsms_convert u_convert (
        .i_prod_temp         (r_in.prod_temp),
        .i_prod_hum          (r_in.prod_hum),
        .i_ok                (n_result.ok),
        .o_temperature_centi (w_temp),
        .o_humidity_centi    (w_hum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_us_per_tick <= 10'd1;
        end else if (i_cfg_we) begin
            r_us_per_tick <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_active_mode   <= hsms_pkg::MODE_SINGLE;
            r_active_repeat <= 2'd0;
            r_started       <= 1'b0;
            r_first         <= 1'b0;
            r_elapsed       <= 16'd0;
        end else if (w_advance) begin
            r_in_valid  <= i_in.valid;
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_active_mode   <= n_active_mode;
                r_active_repeat <= n_active_repeat;
                r_started       <= n_started;
                r_first         <= n_first;
                r_elapsed       <= n_elapsed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            if (i_in.valid) begin
                r_in <= w_in;
            end
            if (r_in_valid) begin
                r_out_status    <= n_result.status;
                r_out_cmd_valid <= n_result.cmd_valid;
                r_out_cmd_word  <= n_result.cmd_word;
                r_out_temp      <= w_temp;
                r_out_hum       <= w_hum;
            end
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_out_status;
    assign o_out.cmd_valid         = r_out_cmd_valid;
    assign o_out.cmd_word          = r_out_cmd_word;
    assign o_out.temperature_centi = r_out_temp;
    assign o_out.humidity_centi    = r_out_hum;

    `HSMS_ASSERT_ALWAYS(a_first_needs_started, i_clk, i_rst_n, !r_first || r_started, "first-measurement flag set without a started measurement")
    `HSMS_ASSERT_ALWAYS(a_periodic_needs_started, i_clk, i_rst_n, r_active_mode == hsms_pkg::MODE_SINGLE || r_started, "periodic mode held without a started measurement")
    `HSMS_ASSERT_IMP(a_no_cmd_zero_word, i_clk, i_rst_n, r_out_valid && !r_out_cmd_valid, r_out_cmd_word == 16'd0, "command word nonzero without a command")
    `HSMS_ASSERT_IMP(a_bad_status_zero_values, i_clk, i_rst_n, r_out_valid && r_out_status != hsms_pkg::ST_OK, r_out_temp == 15'sd0 && r_out_hum == 14'd0, "values nonzero on a failed result")
    `HSMS_ASSERT_NEXT(a_tick_monotonic, i_clk, i_rst_n, w_advance && r_in_valid && r_in.op == hsms_pkg::OP_TICK, r_elapsed >= $past(r_elapsed), "elapsed time decreased on a tick")

endmodule

`default_nettype wire

/* hdl/hsms_convert.sv */
`default_nettype none

module hsms_convert (
    input  wire logic [30:0]        i_prod_temp,
    input  wire logic [29:0]        i_prod_hum,
    input  wire logic               i_ok,
    output logic signed [14:0]      o_temperature_centi,
    output logic [13:0]             o_humidity_centi
);

    // Division by 65535 is exact as (x + (x >> 16) + 1) >> 16 for these ranges.
    logic [31:0] w_sum_temp;
    logic [30:0] w_sum_hum;
    logic [14:0] w_q_temp;
    logic [13:0] w_q_hum;

    assign w_sum_temp = {1'b0, i_prod_temp} + {17'd0, i_prod_temp[30:16]} + 32'd1;
    assign w_sum_hum  = {1'b0, i_prod_hum} + {17'd0, i_prod_hum[29:16]} + 31'd1;
    assign w_q_temp   = w_sum_temp[30:16];
    assign w_q_hum    = w_sum_hum[29:16];

    always_comb begin
        if (i_ok) begin
            o_temperature_centi = $signed(w_q_temp - hsms_pkg::TEMP_OFFSET);
            o_humidity_centi    = w_q_hum;
        end else begin
            o_temperature_centi = 15'sd0;
            o_humidity_centi    = 14'd0;
        end
    end

endmodule

`default_nettype wire
